@@ rtl/xlb_pkg.sv @@
// Shared types, widths and codes for the XOR linear basis engine.
`timescale 1ns / 1ps

package xlb_pkg;

    // Fixed field widths of the request and result words.
    localparam int REQ_W    = 2;
    localparam int VEC_W    = 61;
    localparam int KIDX_W   = 62;
    localparam int RANK_W   = 6;

    // Wide enough to hold two to the power of any rank value.
    localparam int LIM_W    = 2 ** RANK_W;

    // Default highest pivot bit.
    localparam int TOP_BIT_DEF = 60;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REPR   = 2'd1,
        REQ_MAX    = 2'd2,
        REQ_KTH    = 2'd3
    } xlb_req_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } xlb_state_t;

    // Result of one step of the shared slot unit.
    typedef struct packed {
        logic [VEC_W-1:0] acc_next;  // updated working value
        logic             place;     // insert claims this empty slot
        logic             consume;   // a filled slot was visited
    } xlb_step_t;

endpackage

@@ rtl/xlb_if.sv @@
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps

interface xlb_req_if;
    logic                            valid;
    logic                            ready;
    logic [xlb_pkg::REQ_W-1:0]       req_type;
    logic [xlb_pkg::VEC_W-1:0]       vector_value;
    logic [xlb_pkg::VEC_W-1:0]       start_value;
    logic [xlb_pkg::KIDX_W-1:0]      kth_index;

    modport source (
        output valid, req_type, vector_value, start_value, kth_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, vector_value, start_value, kth_index,
        output ready
    );
endinterface

interface xlb_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [xlb_pkg::VEC_W-1:0]       result_value;
    logic                            representable;
    logic                            index_invalid;
    logic [xlb_pkg::RANK_W-1:0]      basis_rank;

    modport source (
        output valid, result_value, representable, index_invalid, basis_rank,
        input  ready
    );
    modport sink (
        input  valid, result_value, representable, index_invalid, basis_rank,
        output ready
    );
endinterface

@@ rtl/xlb_store.sv @@
// Pivot vector memory with one valid bit per slot and a registered read port.
`timescale 1ns / 1ps

module xlb_store #(
    parameter int SLOTS  = xlb_pkg::TOP_BIT_DEF + 1,
    parameter int SLOT_W = $clog2(SLOTS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [SLOT_W-1:0]         rd_addr,
    output logic [xlb_pkg::VEC_W-1:0] rd_data,
    output logic                      rd_valid,
    input  logic                      wr_en,
    input  logic [SLOT_W-1:0]         wr_addr,
    input  logic [xlb_pkg::VEC_W-1:0] wr_data
);

    logic [xlb_pkg::VEC_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]          valid_reg;
    logic [xlb_pkg::VEC_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: a slot that was never written reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ rtl/xlb_alu.sv @@
// Shared slot unit: one reduce, insert, max or kth step against one pivot.
`timescale 1ns / 1ps

module xlb_alu #(
    parameter int SLOT_W = 6
) (
    input  xlb_pkg::xlb_req_t         op,
    input  logic [xlb_pkg::VEC_W-1:0] acc,
    input  logic [xlb_pkg::VEC_W-1:0] pivot,
    input  logic                      pivot_valid,
    input  logic [SLOT_W-1:0]         slot,
    input  logic                      kbit,
    output xlb_pkg::xlb_step_t        step
);

    logic [xlb_pkg::VEC_W-1:0] shifted;
    logic [xlb_pkg::VEC_W-1:0] alt;
    logic                      lead;
    logic                      gt;

    // Working value bit at this slot, and the candidate with the pivot folded in.
    assign shifted = acc >> slot;
    assign lead    = shifted[0];
    assign alt     = acc ^ pivot;
    assign gt      = (alt > acc);

    always_comb
    begin
        step          = '0;
        step.acc_next = acc;
        case (op)
            xlb_pkg::REQ_INSERT:
            begin
                // Claim the first empty slot whose bit is set, else reduce.
                if (lead)
                begin
                    if (!pivot_valid)
                    begin
                        step.place = 1'b1;
                    end
                    else
                    begin
                        step.acc_next = alt;
                    end
                end
            end
            xlb_pkg::REQ_REPR:
            begin
                if (lead && pivot_valid)
                begin
                    step.acc_next = alt;
                end
            end
            xlb_pkg::REQ_MAX:
            begin
                if (pivot_valid && gt)
                begin
                    step.acc_next = alt;
                end
            end
            xlb_pkg::REQ_KTH:
            begin
                // A stored pivot is never zero, so alt never equals acc.
                if (pivot_valid)
                begin
                    step.consume = 1'b1;
                    if (kbit ? gt : !gt)
                    begin
                        step.acc_next = alt;
                    end
                end
            end
            default:
            begin
                step.acc_next = acc;
            end
        endcase
    end

endmodule

@@ rtl/xor_linear_basis_engine.sv @@
// Top level of the XOR linear basis engine: sequencer, working registers, result stage.
//
//  Channel | Dir | Fields                                                  | Handshake
//  req     | in  | req_type, vector_value, start_value, kth_index          | valid/ready
//  rsp     | out | result_value, representable, index_invalid, basis_rank  | valid/ready
//
// Each word but an out-of-range kth query walks the pivot slots from TOP_BIT
// down to 0, one slot per cycle through the shared slot unit and the single
// read port of the pivot memory. Between one accept and the next a query
// passes the check, walk and finish states; an insert stops at the slot it
// fills. Ready is high only while the sequencer is idle, and a full result
// register holds the sequencer in its finish state. Reset empties every slot
// at once through per-slot valid bits and clears the rank. A finished result
// waits in the output register; the next word is accepted meanwhile.
`timescale 1ns / 1ps

module xor_linear_basis_engine #(
    parameter int TOP_BIT = xlb_pkg::TOP_BIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    xlb_req_if.sink    req,
    xlb_rsp_if.source  rsp
);

    localparam int SLOTS  = TOP_BIT + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int VEC_W  = xlb_pkg::VEC_W;
    localparam logic [VEC_W-1:0] VEC_MASK =
        (SLOTS >= VEC_W) ? {VEC_W{1'b1}} : VEC_W'((64'(1) << SLOTS) - 64'd1);

    xlb_pkg::xlb_state_t            state_reg, state_next;
    xlb_pkg::xlb_req_t              op_reg, op_next;
    logic [VEC_W-1:0]               acc_reg, acc_next;
    logic [xlb_pkg::KIDX_W-1:0]     k_reg, k_next;
    logic [xlb_pkg::RANK_W-1:0]     j_reg, j_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic [xlb_pkg::RANK_W-1:0]     rank_reg, rank_next;
    logic                           bad_reg, bad_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic [VEC_W-1:0]               rsp_value_reg, rsp_value_next;
    logic                           rsp_repr_reg, rsp_repr_next;
    logic                           rsp_bad_reg, rsp_bad_next;
    logic [xlb_pkg::RANK_W-1:0]     rsp_rank_reg, rsp_rank_next;

    logic                           rd_en;
    logic [SLOT_W-1:0]              rd_addr;
    logic [VEC_W-1:0]               rd_data;
    logic                           rd_valid;
    logic                           wr_en;

    logic [xlb_pkg::KIDX_W-1:0]     k_shift;
    logic                           kbit;
    logic [xlb_pkg::LIM_W-1:0]      k_limit;
    logic                           k_out_of_range;
    logic                           rsp_load;
    xlb_pkg::xlb_step_t             step;

    // Pivot memory.
    xlb_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (slot_reg),
        .wr_data  (acc_reg)
    );

    // Shared slot unit.
    xlb_alu #(
        .SLOT_W (SLOT_W)
    ) u_alu (
        .op          (op_reg),
        .acc         (acc_reg),
        .pivot       (rd_data),
        .pivot_valid (rd_valid),
        .slot        (slot_reg),
        .kbit        (kbit),
        .step        (step)
    );

    // Bit of k - 1 that steers the current kth step, and the range check on k.
    assign k_shift        = k_reg >> j_reg;
    assign kbit           = k_shift[0];
    assign k_limit        = xlb_pkg::LIM_W'(1) << rank_reg;
    assign k_out_of_range = (k_reg == '0) || (xlb_pkg::LIM_W'(k_reg) > k_limit);

    // Sequencer next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        slot_next      = slot_reg;
        rank_next      = rank_reg;
        bad_next       = bad_reg;
        rd_en          = 1'b0;
        rd_addr        = slot_reg;
        wr_en          = 1'b0;
        rsp_load       = 1'b0;
        req.ready      = 1'b0;

        case (state_reg)
            xlb_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next = xlb_pkg::xlb_req_t'(req.req_type);
                    k_next  = req.kth_index;
                    case (xlb_pkg::xlb_req_t'(req.req_type))
                        xlb_pkg::REQ_MAX: acc_next = req.start_value & VEC_MASK;
                        xlb_pkg::REQ_KTH: acc_next = '0;
                        default:          acc_next = req.vector_value & VEC_MASK;
                    endcase
                    state_next = xlb_pkg::ST_CHECK;
                end
            end
            xlb_pkg::ST_CHECK:
            begin
                if (op_reg == xlb_pkg::REQ_KTH && k_out_of_range)
                begin
                    bad_next   = 1'b1;
                    state_next = xlb_pkg::ST_FINISH;
                end
                else
                begin
                    // Start the walk at the top slot.
                    bad_next   = 1'b0;
                    k_next     = k_reg - xlb_pkg::KIDX_W'(1);
                    j_next     = rank_reg - xlb_pkg::RANK_W'(1);
                    slot_next  = SLOT_W'(TOP_BIT);
                    rd_en      = 1'b1;
                    rd_addr    = SLOT_W'(TOP_BIT);
                    state_next = xlb_pkg::ST_WALK;
                end
            end
            xlb_pkg::ST_WALK:
            begin
                if (step.consume)
                begin
                    j_next = j_reg - xlb_pkg::RANK_W'(1);
                end
                if (step.place)
                begin
                    // Store the reduced vector in its pivot slot and stop.
                    wr_en      = 1'b1;
                    rank_next  = rank_reg + xlb_pkg::RANK_W'(1);
                    state_next = xlb_pkg::ST_FINISH;
                end
                else
                begin
                    acc_next = step.acc_next;
                    if (slot_reg == '0)
                    begin
                        state_next = xlb_pkg::ST_FINISH;
                    end
                    else
                    begin
                        slot_next = slot_reg - SLOT_W'(1);
                        rd_en     = 1'b1;
                        rd_addr   = slot_reg - SLOT_W'(1);
                    end
                end
            end
            xlb_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = xlb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xlb_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word formed from the working registers.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_value_next = rsp_value_reg;
        rsp_repr_next  = rsp_repr_reg;
        rsp_bad_next   = rsp_bad_reg;
        rsp_rank_next  = rsp_rank_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_value_next = ((op_reg == xlb_pkg::REQ_MAX) || (op_reg == xlb_pkg::REQ_KTH))
                             ? acc_reg : '0;
            rsp_repr_next  = (op_reg == xlb_pkg::REQ_REPR) && (acc_reg == '0);
            rsp_bad_next   = (op_reg == xlb_pkg::REQ_KTH) && bad_reg;
            rsp_rank_next  = rank_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xlb_pkg::ST_IDLE;
            rank_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        acc_reg       <= acc_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        slot_reg      <= slot_next;
        bad_reg       <= bad_next;
        rsp_value_reg <= rsp_value_next;
        rsp_repr_reg  <= rsp_repr_next;
        rsp_bad_reg   <= rsp_bad_next;
        rsp_rank_reg  <= rsp_rank_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.result_value  = rsp_value_reg;
    assign rsp.representable = rsp_repr_reg;
    assign rsp.index_invalid = rsp_bad_reg;
    assign rsp.basis_rank    = rsp_rank_reg;

    // The memory is written only by an insert during the slot walk.
    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == xlb_pkg::ST_WALK) && (op_reg == xlb_pkg::REQ_INSERT))
        else $error("pivot write outside an insert walk");

    // The rank changes only when a slot is filled.
    a_rank_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> $stable(rank_reg))
        else $error("rank changed without a pivot write");

    // The rank never exceeds the number of slots.
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= xlb_pkg::RANK_W'(SLOTS))
        else $error("rank above slot count");

    // A new result appears only out of the finish state.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == xlb_pkg::ST_FINISH))
        else $error("result raised outside finish");

    // The two flags never come together in one result.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_repr_reg && rsp_bad_reg))
        else $error("representable and index_invalid both set");

endmodule

@@ sim/tb_xor_linear_basis_engine.sv @@
// Self-checking testbench for the XOR linear basis engine with its own basis predictor.
`timescale 1ns / 1ps

module tb_xor_linear_basis_engine;

    localparam int TOP         = xlb_pkg::TOP_BIT_DEF;
    localparam int VEC_W       = xlb_pkg::VEC_W;
    localparam int KIDX_W      = xlb_pkg::KIDX_W;
    localparam int RANK_W      = xlb_pkg::RANK_W;
    localparam int PERIOD      = 12;
    localparam int MAX_GAP     = 17;
    localparam int HOLD_CYC    = 300;
    localparam int WATCHDOG    = 2000;
    localparam int TAIL_CYC    = 2 * (TOP + 5);
    localparam int PHASE_LEN   = 275;
    localparam int N_PHASES    = 6;
    localparam logic [VEC_W-1:0]  ONES  = '1;
    localparam logic [KIDX_W-1:0] K_TOP = 62'h2000_0000_0000_0000;

    // Inserted vectors may use only the low bits of each phase, so the rank climbs in steps.
    localparam int PHASE_WIDTHS [N_PHASES] = '{3, 8, 20, 40, 61, 61};

    typedef struct packed {
        xlb_pkg::xlb_req_t op;
        logic [VEC_W-1:0]  vec;
        logic [VEC_W-1:0]  start;
        logic [KIDX_W-1:0] kidx;
    } basis_word_t;

    typedef struct packed {
        logic [VEC_W-1:0]  value;
        logic              repr;
        logic              bad;
        logic [RANK_W-1:0] rank;
    } basis_reply_t;

    typedef struct packed {
        basis_word_t  word;
        logic         typed;
        basis_reply_t reply;
    } directed_row_t;

    // Directed words: empty basis first, then a small basis of rank three, grown to four by the last insert.
    // Rows with typed set carry the reply that can be read off directly.
    localparam int DIR_N = 25;
    localparam directed_row_t DIRECTED [DIR_N] = '{
        '{'{xlb_pkg::REQ_REPR,   61'h0, 61'h0, 62'h0}, 1'b1, '{61'h0, 1'b1, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_REPR,   ONES,  61'h0, 62'h0}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_MAX,    61'h0, ONES,  62'h0}, 1'b1, '{ONES,  1'b0, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_MAX,    ONES,  61'h0, 62'h0}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h0}, 1'b1, '{61'h0, 1'b0, 1'b1, 6'd0}},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h1}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h2}, 1'b1, '{61'h0, 1'b0, 1'b1, 6'd0}},
        '{'{xlb_pkg::REQ_KTH,    ONES,  ONES,  K_TOP}, 1'b1, '{61'h0, 1'b0, 1'b1, 6'd0}},
        '{'{xlb_pkg::REQ_INSERT, 61'h0, ONES,  62'h0}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd0}},
        '{'{xlb_pkg::REQ_INSERT, ONES,  61'h0, 62'h0}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd1}},
        '{'{xlb_pkg::REQ_INSERT, ONES,  ONES,  K_TOP}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd1}},
        '{'{xlb_pkg::REQ_INSERT, 61'h1, 61'h0, 62'h0}, 1'b1, '{61'h0, 1'b0, 1'b0, 6'd2}},
        '{'{xlb_pkg::REQ_INSERT, 61'h1000_0000_0000_0000, 61'h0, 62'h0},
          1'b1, '{61'h0, 1'b0, 1'b0, 6'd3}},
        '{'{xlb_pkg::REQ_REPR,   ONES,  61'h0, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_REPR,   61'h2, 61'h0, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_REPR,   61'h1FFF_FFFF_FFFF_FFFE, 61'h0, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_MAX,    61'h0, 61'h0, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_MAX,    61'h0, ONES,  62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h1}, 1'b0, '0},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h8}, 1'b0, '0},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, 62'h9}, 1'b1, '{61'h0, 1'b0, 1'b1, 6'd3}},
        '{'{xlb_pkg::REQ_KTH,    61'h0, 61'h0, K_TOP}, 1'b1, '{61'h0, 1'b0, 1'b1, 6'd3}},
        '{'{xlb_pkg::REQ_INSERT, 61'h0AAA_AAAA_AAAA_AAAA, 61'h0, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_MAX,    61'h0, 61'h1555_5555_5555_5555, 62'h0}, 1'b0, '0},
        '{'{xlb_pkg::REQ_REPR,   61'h1000_0000_0000_0001, 61'h0, 62'h0}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    xlb_req_if req_ch ();
    xlb_rsp_if rsp_ch ();

    xor_linear_basis_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Predicted basis: one pivot per leading bit, zero meaning empty.
    logic [VEC_W-1:0]  span_pivots [0:TOP];
    logic [RANK_W-1:0] span_rank;

    basis_reply_t pending_replies [$];
    int           mismatch_count = 0;
    logic         calm_mode      = 1'b0;
    logic         hold_request   = 1'b0;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    function automatic int pick_gap();
        return calm_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VEC_W-1:0];
    endfunction

    // XOR of a random subset of the current pivots, always inside the span.
    function automatic logic [VEC_W-1:0] span_member();
        logic [VEC_W-1:0] acc;
        int i;
        acc = '0;
        for (i = TOP; i >= 0; i--)
        begin
            if (span_pivots[i] != '0 && $urandom_range(0, 1) == 1)
                acc ^= span_pivots[i];
        end
        return acc;
    endfunction

    // Reduce from the top bit down; zero means the vector lies in the span.
    function automatic logic [VEC_W-1:0] reduce_vec(input logic [VEC_W-1:0] x);
        logic [VEC_W-1:0] acc;
        int i;
        acc = x;
        for (i = TOP; i >= 0; i--)
        begin
            if (acc[i] && span_pivots[i] != '0)
                acc ^= span_pivots[i];
        end
        return acc;
    endfunction

    // Store the reduced vector in the first empty pivot slot it reaches.
    function automatic void absorb_vec(input logic [VEC_W-1:0] x);
        logic [VEC_W-1:0] acc;
        logic placed;
        int i;
        acc = x;
        placed = 1'b0;
        for (i = TOP; i >= 0 && !placed; i--)
        begin
            if (acc[i])
            begin
                if (span_pivots[i] == '0)
                begin
                    span_pivots[i] = acc;
                    span_rank++;
                    placed = 1'b1;
                end
                else
                begin
                    acc ^= span_pivots[i];
                end
            end
        end
    endfunction

    // Greedy walk: take a pivot whenever it makes the value larger.
    function automatic logic [VEC_W-1:0] max_with(input logic [VEC_W-1:0] seed);
        logic [VEC_W-1:0] acc;
        logic [VEC_W-1:0] alt;
        int i;
        acc = seed;
        for (i = TOP; i >= 0; i--)
        begin
            if (span_pivots[i] != '0)
            begin
                alt = acc ^ span_pivots[i];
                if (alt > acc)
                    acc = alt;
            end
        end
        return acc;
    endfunction

    // The bits of k-1 pick larger or smaller at each filled slot, top first.
    function automatic basis_reply_t kth_element(input logic [KIDX_W-1:0] k);
        basis_reply_t rep;
        logic [63:0] lim;
        logic [63:0] kz;
        logic [VEC_W-1:0] acc;
        logic [VEC_W-1:0] alt;
        int i;
        int j;
        rep = '0;
        lim = 64'd1 << span_rank;
        if (k == '0 || 64'(k) > lim)
        begin
            rep.bad = 1'b1;
            return rep;
        end
        kz = 64'(k) - 64'd1;
        acc = '0;
        j = int'(span_rank) - 1;
        for (i = TOP; i >= 0 && j >= 0; i--)
        begin
            if (span_pivots[i] != '0)
            begin
                alt = acc ^ span_pivots[i];
                if (kz[j])
                begin
                    if (alt > acc)
                        acc = alt;
                end
                else
                begin
                    if (alt < acc)
                        acc = alt;
                end
                j--;
            end
        end
        rep.value = acc;
        return rep;
    endfunction

    // Expected reply of one word; updates the predicted basis on insert.
    function automatic basis_reply_t predict_reply(input basis_word_t w);
        basis_reply_t rep;
        rep = '0;
        case (w.op)
            xlb_pkg::REQ_INSERT: absorb_vec(w.vec);
            xlb_pkg::REQ_REPR:   rep.repr = (reduce_vec(w.vec) == '0);
            xlb_pkg::REQ_MAX:    rep.value = max_with(w.start);
            default:             rep = kth_element(w.kidx);
        endcase
        rep.rank = span_rank;
        return rep;
    endfunction

    // Random word: mostly well-formed requests against the current basis.
    function automatic basis_word_t make_word(input int width);
        basis_word_t w;
        logic [VEC_W-1:0] mask;
        logic [63:0] lim;
        logic [63:0] k;
        int roll;
        mask = ONES >> (VEC_W - width);
        w.vec = rand_vec();
        w.start = rand_vec();
        w.kidx = {1'b0, rand_vec()};
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            w.op = xlb_pkg::REQ_INSERT;
            case ($urandom_range(0, 9))
                0:       w.vec = '0;
                1, 2:    w.vec = span_member();
                default: w.vec = rand_vec() & mask;
            endcase
        end
        else if (roll < 55)
        begin
            w.op = xlb_pkg::REQ_REPR;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: w.vec = span_member();
                5:             w.vec = '0;
                9:             w.vec = rand_vec();
                default:       w.vec = rand_vec() & mask;
            endcase
        end
        else if (roll < 75)
        begin
            w.op = xlb_pkg::REQ_MAX;
        end
        else
        begin
            w.op = xlb_pkg::REQ_KTH;
            lim = 64'd1 << span_rank;
            case ($urandom_range(0, 7))
                0:       k = 64'd0;
                1:       k = 64'd1;
                2:       k = lim;
                3:       k = (span_rank == RANK_W'(TOP + 1)) ? lim : lim + 64'd1;
                default: k = ({$urandom, $urandom} % lim) + 64'd1;
            endcase
            w.kidx = k[KIDX_W-1:0];
        end
        return w;
    endfunction

    // Offer one word after a random gap and record its reply once accepted.
    task automatic offer_word(input basis_word_t w, input basis_reply_t typed_reply,
                              input logic use_typed);
        int gap;
        basis_reply_t rep;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= w.op;
        req_ch.vector_value <= w.vec;
        req_ch.start_value  <= w.start;
        req_ch.kth_index    <= w.kidx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rep = predict_reply(w);
        pending_replies.push_back(use_typed ? typed_reply : rep);
    endtask

    // Stop offering until every pending reply has come back.
    task automatic settle_replies();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Stimulus: reset, directed rows, then random phases of growing vector width.
    initial
    begin : stimulus
        int r;
        int p;
        int n;
        for (r = 0; r <= TOP; r++)
            span_pivots[r] = '0;
        span_rank = '0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= xlb_pkg::REQ_INSERT;
        req_ch.vector_value <= '0;
        req_ch.start_value  <= '0;
        req_ch.kth_index    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_N; r++)
            offer_word(DIRECTED[r].word, DIRECTED[r].reply, DIRECTED[r].typed);
        settle_replies();

        for (p = 0; p < N_PHASES; p++)
        begin
            // Long receiver stall while words keep coming, to fill the block.
            if (p == 2)
                hold_request = 1'b1;
            for (n = 0; n < PHASE_LEN; n++)
            begin
                if (n % 40 == 0)
                    calm_mode = ($urandom_range(0, 3) == 0);
                offer_word(make_word(PHASE_WIDTHS[p]), '0, 1'b0);
            end
            settle_replies();
        end

        repeat (TAIL_CYC) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_xor_linear_basis_engine: PASS");
        else
            $display("tb_xor_linear_basis_engine: FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold on request, field-by-field check.
    initial
    begin : receiver
        int gap;
        basis_reply_t want;
        forever
        begin
            gap = pick_gap();
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYC;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result word with none expected, value 0x%0h rank %0d",
                         $time, rsp_ch.result_value, rsp_ch.basis_rank);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.result_value !== want.value)
                    note_mismatch("result_value", 64'(want.value), 64'(rsp_ch.result_value));
                if (rsp_ch.representable !== want.repr)
                    note_mismatch("representable", 64'(want.repr), 64'(rsp_ch.representable));
                if (rsp_ch.index_invalid !== want.bad)
                    note_mismatch("index_invalid", 64'(want.bad), 64'(rsp_ch.index_invalid));
                if (rsp_ch.basis_rank !== want.rank)
                    note_mismatch("basis_rank", 64'(want.rank), 64'(rsp_ch.basis_rank));
            end
        end
    end

    // Watchdog: too many cycles without a word moving on either channel.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_xor_linear_basis_engine: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/xlb_pkg.sv
rtl/xlb_if.sv
rtl/xlb_store.sv
rtl/xlb_alu.sv
rtl/xor_linear_basis_engine.sv
sim/tb_xor_linear_basis_engine.sv
